// File: design/itd_pkg.sv
package itd_pkg;

   localparam int KIND_W   = 2;
   localparam int IN_VAL_W = 32;
   localparam int CHAR_W   = 8;

   // request kinds; the unused code decodes by its high bit as hex
   localparam logic [KIND_W-1:0] KIND_UDEC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SDEC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HEX  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 8'h57;
   localparam logic [CHAR_W-1:0] CHAR_MINUS      = 8'h2d;
   localparam logic [3:0]        DEC_BASE        = 4'd10;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [IN_VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_SCAN,
      ST_SEND
   } state_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] dgt);
      logic [CHAR_W-1:0] base;
      base = (dgt < DEC_BASE) ? CHAR_ZERO : CHAR_ALPHA_BASE;
      return base + CHAR_W'(dgt);
   endfunction

endpackage

// File: design/integer_to_text_digits.sv
// sequence: a decimal request runs the shift-add-3 conversion, then the sign state, which sends a minus
//   sign for a negative value, then the scan, which skips leading zeros, and then the digits are sent;
//   a hex request skips the conversion and goes straight to the sign state
// throughput: one request at a time, then one character per cycle while rsp_stall is low;
//   the decimal conversion is the one-bit-per-cycle shift-add-3 loop
// reset: synchronous, clears the sequencer and the result valid; digit store is not cleared
module integer_to_text_digits
   import itd_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // decimal digits needed: floor(w * log10(2)) + 1
   localparam int NUM_DEC = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int NUM_HEX = (VALUE_WIDTH + 3) / 4;
   localparam int NUM_DIG = (NUM_DEC > NUM_HEX) ? NUM_DEC : NUM_HEX;
   localparam int PTR_W   = (NUM_DIG > 1) ? $clog2(NUM_DIG) : 1;
   localparam int CNT_W   = $clog2(VALUE_WIDTH);

   // sequencer
   state_type state_ff, state_in;

   // working registers
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [3:0]             dig_ff [NUM_DIG];
   logic [3:0]             dig_in [NUM_DIG];
   logic                   neg_ff, neg_in;
   logic                   hex_ff, hex_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // helpers
   logic                   req_take;
   logic                   out_free;
   logic [3:0]             cur_dig;
   logic                   conv_done;
   logic [VALUE_WIDTH-1:0] val_in;
   logic                   val_neg;
   logic [4*NUM_DIG-1:0]   nib_pad;
   logic [3:0]             adj [NUM_DIG];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_dig   = dig_ff[ptr_ff];
   assign conv_done = (cnt_ff == CNT_W'(VALUE_WIDTH - 1));

   // input masked to the working width, negated in signed mode when the sign bit is set
   assign val_in  = VALUE_WIDTH'(req_data.value);
   assign val_neg = (req_data.kind == KIND_SDEC) && val_in[VALUE_WIDTH-1];
   assign nib_pad = (4*NUM_DIG)'(val_in);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // hex needs no conversion: nibbles are the digits
               state_in = req_data.kind[1] ? ST_SIGN : ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!neg_ff || out_free) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // leading zeros skipped one per cycle; digit zero always printed
            if (cur_dig != 4'd0 || ptr_ff == '0) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (out_free && ptr_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // shift-add-3 lane adjust: each bcd digit of 5 or more gets 3 added before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIG; i++) begin
         adj[i] = (dig_ff[i] >= 4'd5) ? dig_ff[i] + 4'd3 : dig_ff[i];
      end
   end

   // datapath and result register
   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      hex_in       = hex_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      for (int i = 0; i < NUM_DIG; i++) begin
         dig_in[i] = dig_ff[i];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mag_in = val_neg ? (~val_in + VALUE_WIDTH'(1)) : val_in;
               neg_in = val_neg;
               hex_in = req_data.kind[1];
               cnt_in = '0;
               for (int i = 0; i < NUM_DIG; i++) begin
                  dig_in[i] = req_data.kind[1] ? nib_pad[4*i +: 4] : 4'd0;
               end
            end
         end
         ST_CONV: begin
            // one magnitude bit enters the bcd chain per cycle, msb first
            dig_in[0] = {adj[0][2:0], mag_ff[VALUE_WIDTH-1]};
            for (int i = 1; i < NUM_DIG; i++) begin
               dig_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_SIGN: begin
            ptr_in = hex_ff ? PTR_W'(NUM_HEX - 1) : PTR_W'(NUM_DEC - 1);
            if (neg_ff && out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.text_char = CHAR_MINUS;
               rsp_data_in.last      = 1'b0;
            end
         end
         ST_SCAN: begin
            if (cur_dig == 4'd0 && ptr_ff != '0) begin
               ptr_in = ptr_ff - PTR_W'(1);
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.text_char = digit_char(cur_dig);
               rsp_data_in.last      = (ptr_ff == '0);
               if (ptr_ff != '0) begin
                  ptr_in = ptr_ff - PTR_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      hex_ff      <= hex_in;
      cnt_ff      <= cnt_in;
      ptr_ff      <= ptr_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < NUM_DIG; i++) begin
         dig_ff[i] <= dig_in[i];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a taken request always starts the sequencer
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("request taken but sequencer stayed idle");

   // the lowest digit sent is marked last
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && out_free && ptr_ff == '0) |=> rsp_data_ff.last)
      else $error("final character not marked last");

   // hex never runs the bcd conversion
   a_hex_noconv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !hex_ff)
      else $error("bcd conversion running on a hex request");

   // after conversion every decimal digit is in range
   a_bcd_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN || state_ff == ST_SEND) && !hex_ff) |-> (cur_dig < DEC_BASE))
      else $error("bcd digit out of range");

endmodule
